/* rtl/core/sorted_event_queue_defines.svh */
// ----------------------------------------------------------------------------
// sorted_event_queue_defines.svh
// Assertion macros used by the sorted event queue controller (seq_ctrl).
// ----------------------------------------------------------------------------
`ifndef SORTED_EVENT_QUEUE_DEFINES_SVH
`define SORTED_EVENT_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define SEQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define SEQ_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SEQ_ASSERT(label, clk, rst, prop, msg)
`define SEQ_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

/* rtl/core/seq_pkg.sv */
// ----------------------------------------------------------------------------
// seq_pkg
// Types and codes shared by the sorted event queue modules.
// ----------------------------------------------------------------------------
package seq_pkg;

   // Operation codes carried on req_func
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INS_CMP,
      S_INS_PUT,
      S_REM
   } state_type;

   typedef struct packed {
      logic       out_valid;
      status_type status;
   } rsp_flags_type;

endpackage

/* rtl/core/seq_ram.sv */
// ----------------------------------------------------------------------------
// seq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module seq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/seq_ctrl.sv */
// ----------------------------------------------------------------------------
// seq_ctrl
// Sequencer for the sorted event queue: ring pointers, occupancy and the
// insertion walk over the entry memory, plus the registered result.
// ----------------------------------------------------------------------------
`include "sorted_event_queue_defines.svh"

module seq_ctrl #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_BITS   = 32,
   parameter int TAG_BITS    = 16,
   localparam int IDX_W = $clog2(QUEUE_DEPTH),
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
   localparam int MEM_W = TIME_BITS + TAG_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_func,
   input  logic [TIME_BITS-1:0]  req_event_time,
   input  logic [TAG_BITS-1:0]   req_event_tag,
   output logic                  mem_wr_en,
   output logic [IDX_W-1:0]      mem_wr_addr,
   output logic [MEM_W-1:0]      mem_wr_data,
   output logic                  mem_rd_en,
   output logic [IDX_W-1:0]      mem_rd_addr,
   input  logic [MEM_W-1:0]      mem_rd_data,
   output logic                  rsp_strobe,
   output logic [TIME_BITS-1:0]  rsp_time,
   output logic [TAG_BITS-1:0]   rsp_tag,
   output seq_pkg::rsp_flags_type rsp_flags,
   output logic [CNT_W-1:0]      rsp_occupancy
);

   import seq_pkg::*;

   localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [TIME_BITS-1:0] rsp_time_ff, rsp_time_in;
   logic [TAG_BITS-1:0]  rsp_tag_ff, rsp_tag_in;
   rsp_flags_type        rsp_flags_ff, rsp_flags_in;
   logic [CNT_W-1:0]     rsp_occ_ff, rsp_occ_in;

   logic                 accept;
   logic                 is_full;
   logic                 is_empty;
   logic [TIME_BITS-1:0] rd_time;
   logic [TAG_BITS-1:0]  rd_tag;
   logic                 shift;
   logic [IDX_W-1:0]     count_idx;

   // Logical slot to physical address: one compare and subtract on the ring.
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                             input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[IDX_W-1:0];
   endfunction

   assign accept    = start && (state_ff == S_IDLE);
   assign is_full   = (count_ff == CNT_FULL);
   assign is_empty  = (count_ff == '0);
   assign rd_time   = mem_rd_data[MEM_W-1 -: TIME_BITS];
   assign rd_tag    = mem_rd_data[TAG_BITS-1:0];
   assign shift     = (rd_time >= time_ff);
   assign count_idx = count_ff[IDX_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_INSERT && !is_full) begin
                  state_in = is_empty ? S_INS_PUT : S_INS_CMP;
               end else if (req_func == FUNC_REMOVE && !is_empty) begin
                  state_in = S_REM;
               end
            end
         end
         S_INS_CMP: begin
            if (shift) begin
               state_in = (k_ff == IDX_W'(1)) ? S_INS_PUT : S_INS_CMP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_INS_PUT: state_in = S_IDLE;
         S_REM:     state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      time_in       = time_ff;
      tag_in        = tag_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = phys(head_ff, k_ff);
      mem_wr_data   = {time_ff, tag_ff};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = phys(head_ff, k_ff - IDX_W'(2));
      rsp_strobe_in = 1'b0;
      rsp_time_in   = '0;
      rsp_tag_in    = '0;
      rsp_flags_in  = '{out_valid: 1'b0, status: ST_OK};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               time_in = req_event_time;
               tag_in  = req_event_tag;
               k_in    = count_idx;
               if (req_func == FUNC_INSERT) begin
                  if (is_full) begin
                     // drop the event and flag it
                     rsp_strobe_in       = 1'b1;
                     rsp_flags_in.status = ST_FULL;
                  end else if (!is_empty) begin
                     // fetch the last entry to start the walk
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = phys(head_ff, count_idx - IDX_W'(1));
                  end
               end else begin
                  if (is_empty) begin
                     rsp_strobe_in       = 1'b1;
                     rsp_flags_in.status = ST_EMPTY;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = head_ff;
                  end
               end
            end
         end
         S_INS_CMP: begin
            mem_wr_en = 1'b1;
            if (shift) begin
               // move the entry up one slot and fetch the next one down
               mem_wr_data = mem_rd_data;
               k_in        = k_ff - IDX_W'(1);
               mem_rd_en   = (k_ff != IDX_W'(1));
            end else begin
               count_in      = count_ff + CNT_W'(1);
               rsp_strobe_in = 1'b1;
            end
         end
         S_INS_PUT: begin
            mem_wr_en     = 1'b1;
            count_in      = count_ff + CNT_W'(1);
            rsp_strobe_in = 1'b1;
         end
         S_REM: begin
            head_in                = phys(head_ff, IDX_W'(1));
            count_in               = count_ff - CNT_W'(1);
            rsp_strobe_in          = 1'b1;
            rsp_time_in            = rd_time;
            rsp_tag_in             = rd_tag;
            rsp_flags_in.out_valid = 1'b1;
         end
         default: begin
         end
      endcase

      rsp_occ_in = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      time_ff      <= time_in;
      tag_ff       <= tag_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_occ_ff   <= rsp_occ_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_time      = rsp_time_ff;
   assign rsp_tag       = rsp_tag_ff;
   assign rsp_flags     = rsp_flags_ff;
   assign rsp_occupancy = rsp_occ_ff;

   `SEQ_ASSERT(a_count_range, clock, reset, count_ff <= CNT_FULL, "occupancy beyond depth")
   `SEQ_ASSERT(a_done_strobe, clock, reset, (state_ff != S_IDLE) && (state_in == S_IDLE) |=> rsp_strobe_ff, "finished item gave no result")
   `SEQ_ASSERT(a_rem_count, clock, reset, state_ff == S_REM |=> count_ff == $past(count_ff) - CNT_W'(1), "removal did not lower occupancy")
   `SEQ_ASSERT_NEVER(a_walk_slot, clock, reset, (state_ff == S_INS_CMP) && (k_ff == '0), "insert walk below slot zero")
   `SEQ_ASSERT(a_valid_ok, clock, reset, rsp_strobe_ff && rsp_flags_ff.out_valid |-> rsp_flags_ff.status == ST_OK, "removed event with error status")

endmodule

/* rtl/core/sorted_event_queue.sv */
// Insert: busy while each stored entry with time >= the new time moves up a slot
//   and the new event is written; the result strobe rises as busy falls.
// Remove: busy in S_REM (one RAM read), result strobe in the next cycle.
// Dropped insert or empty removal: no busy, result strobe in the next cycle.
// The entry RAM's single write port sets the insert time: one slot per cycle.
// Reset clears occupancy and ring head; the RAM is not cleared.
// ----------------------------------------------------------------------------
// sorted_event_queue
// Time-ordered event queue held in a ring buffer in one RAM, earliest first.
// ----------------------------------------------------------------------------
module sorted_event_queue #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_BITS   = 32,
   parameter int TAG_BITS    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_func,
   input  logic [TIME_BITS-1:0]                 req_event_time,
   input  logic [TAG_BITS-1:0]                  req_event_tag,
   output logic                                 rsp_strobe,
   output logic [TIME_BITS-1:0]                 rsp_out_time,
   output logic [TAG_BITS-1:0]                  rsp_out_tag,
   output logic                                 rsp_out_valid,
   output logic [1:0]                           rsp_status,
   output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   rsp_occupancy
);

   import seq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int MEM_W = TIME_BITS + TAG_BITS;

   // Entry memory interface. Each word holds {time, tag}; slot 0 of the
   // queue sits at the ring head, so a removal never moves data.
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [MEM_W-1:0] mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [MEM_W-1:0] mem_rd_data;

   rsp_flags_type    rsp_flags;

   // Sequencer: an insert walks down from the tail, one slot per cycle,
   // moving each entry whose time is not below the new one up by a slot,
   // then drops the new event into the hole. The read of the next slot down
   // overlaps the write of the current one; they never hit the same entry.
   // Every write completes before the next transfer can issue its read, so
   // no forwarding path is needed.
   seq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_BITS   (TIME_BITS),
      .TAG_BITS    (TAG_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_event_time (req_event_time),
      .req_event_tag  (req_event_tag),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_time       (rsp_out_time),
      .rsp_tag        (rsp_out_tag),
      .rsp_flags      (rsp_flags),
      .rsp_occupancy  (rsp_occupancy)
   );

   // Entry store: times and tags side by side in one word
   seq_ram #(
      .WIDTH (MEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Unpack the result flags onto their ports
   assign rsp_out_valid = rsp_flags.out_valid;
   assign rsp_status    = rsp_flags.status;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_event_queue. It drives insert and remove
// commands with random gaps, keeps its own sorted copy of the stored events,
// and checks every response strobe field by field against that copy.
// ----------------------------------------------------------------------------
module tb;
   import seq_pkg::*;

   localparam int DEPTH      = 16;
   localparam int TIME_W     = 32;
   localparam int TAG_W      = 16;
   localparam int OCC_W      = $clog2(DEPTH + 1);
   localparam int N_RANDOM   = 400;
   // Sized with room to spare over the longest insert walk plus the longest gap
   // from pick_gap for every command of the run.
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = DEPTH + 8;

   // One response as the queue should report it
   typedef struct packed {
      logic [TIME_W-1:0] ev_time;
      logic [TAG_W-1:0]  ev_tag;
      logic              removed;
      status_type        status;
      logic [OCC_W-1:0]  occ;
   } departure_type;

   // Sorted copy of the stored events, plus the responses still to come.
   class queue_scoreboard;
      logic [TIME_W-1:0] slot_time [DEPTH];
      logic [TAG_W-1:0]  slot_tag  [DEPTH];
      int                stored;
      departure_type     due_departures [$];
      int                errors;

      function new();
         stored = 0;
         errors = 0;
      endfunction

      // Apply one accepted command to the copy and queue its response.
      function void note_item(logic func, logic [TIME_W-1:0] t, logic [TAG_W-1:0] g);
         departure_type d;
         int            pos;
         int            k;
         d = '0;
         d.status = ST_OK;
         if (func == FUNC_INSERT) begin
            if (stored >= DEPTH) begin
               d.status = ST_FULL;
            end else begin
               // stop at the first equal time: the newcomer goes ahead of it
               pos = 0;
               while (pos < stored && slot_time[pos] < t) pos++;
               for (k = stored; k > pos; k--) begin
                  slot_time[k] = slot_time[k-1];
                  slot_tag[k]  = slot_tag[k-1];
               end
               slot_time[pos] = t;
               slot_tag[pos]  = g;
               stored++;
            end
         end else begin
            if (stored == 0) begin
               d.status = ST_EMPTY;
            end else begin
               d.ev_time = slot_time[0];
               d.ev_tag  = slot_tag[0];
               d.removed = 1'b1;
               for (k = 1; k < stored; k++) begin
                  slot_time[k-1] = slot_time[k];
                  slot_tag[k-1]  = slot_tag[k];
               end
               stored--;
            end
         end
         d.occ = stored[OCC_W-1:0];
         due_departures.insert(due_departures.size(), d);
      endfunction

      function void check_result(logic [TIME_W-1:0] t, logic [TAG_W-1:0] g, logic v,
                                 logic [1:0] st, logic [OCC_W-1:0] occ);
         departure_type d;
         if (due_departures.size() == 0) begin
            $display("%0t: response with nothing outstanding", $time);
            errors++;
            return;
         end
         d = due_departures.pop_front();
         if (t !== d.ev_time) begin
            $display("%0t: out_time expected %h actual %h", $time, d.ev_time, t);
            errors++;
         end
         if (g !== d.ev_tag) begin
            $display("%0t: out_tag expected %h actual %h", $time, d.ev_tag, g);
            errors++;
         end
         if (v !== d.removed) begin
            $display("%0t: out_valid expected %b actual %b", $time, d.removed, v);
            errors++;
         end
         if (st !== d.status) begin
            $display("%0t: status expected %0d actual %0d", $time, d.status, st);
            errors++;
         end
         if (occ !== d.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, d.occ, occ);
            errors++;
         end
      endfunction

      function int pending();
         return due_departures.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_func;
   logic [TIME_W-1:0] req_event_time;
   logic [TAG_W-1:0]  req_event_tag;
   logic              rsp_strobe;
   logic [TIME_W-1:0] rsp_out_time;
   logic [TAG_W-1:0]  rsp_out_tag;
   logic              rsp_out_valid;
   logic [1:0]        rsp_status;
   logic [OCC_W-1:0]  rsp_occupancy;

   queue_scoreboard   sb;
   int                cycle_count;

   sorted_event_queue #(
      .QUEUE_DEPTH (DEPTH),
      .TIME_BITS   (TIME_W),
      .TAG_BITS    (TAG_W)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_event_time (req_event_time),
      .req_event_tag  (req_event_tag),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_time   (rsp_out_time),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Guard against a hung handshake or a lost response.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // Check every strobed response; the receiver can never hold one off.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_result(rsp_out_time, rsp_out_tag, rsp_out_valid, rsp_status,
                         rsp_occupancy);
   end

   // Time values: mostly a narrow range so that equal times meet often,
   // otherwise the full range and values near both ends.
   function automatic logic [TIME_W-1:0] pick_time();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return TIME_W'($urandom_range(0, 7));
         4, 5:       return TIME_W'($urandom);
         6:          return {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 3));
         default:    return TIME_W'($urandom_range(0, 3));
      endcase
   endfunction

   // Present one command from a falling edge and hold it until a rising edge
   // sees start high with busy low; return at the next falling edge.
   task automatic send_item(logic func, logic [TIME_W-1:0] t, logic [TAG_W-1:0] g);
      start          <= 1'b1;
      req_func       <= func;
      req_event_time <= t;
      req_event_tag  <= g;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_item(func, t, g);
      @(negedge clock);
   endtask

   // Drop start, with junk on the request fields meanwhile; n sets the gap length.
   task automatic idle_for(int n);
      if (n > 0) begin
         start          <= 1'b0;
         req_func       <= 1'($urandom);
         req_event_time <= TIME_W'($urandom);
         req_event_tag  <= TAG_W'($urandom);
         repeat (n) @(negedge clock);
      end
   endtask

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   initial begin
      int  n_sent;
      int  phase_left;
      int  insert_pct;
      bit  no_gaps;
      int  i;
      logic f;

      sb             = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_func       = FUNC_INSERT;
      req_event_time = '0;
      req_event_tag  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: removal from an empty queue first.
      send_item(FUNC_REMOVE, '0, '0);
      // Extremes of time and tag.
      send_item(FUNC_INSERT, {TIME_W{1'b1}}, {TAG_W{1'b1}});
      send_item(FUNC_INSERT, '0, '0);
      // Runs of equal times: each newcomer must go ahead of the older ones.
      for (i = 0; i < 6; i++) send_item(FUNC_INSERT, TIME_W'(5), TAG_W'(16'h0100 + i));
      for (i = 0; i < 4; i++) send_item(FUNC_INSERT, '0, TAG_W'(16'h0200 + i));
      send_item(FUNC_INSERT, {TIME_W{1'b1}}, 16'h0300);
      for (i = 0; i < 3; i++) send_item(FUNC_INSERT, TIME_W'(32'h8000_0000 - i),
                                        TAG_W'(16'h0400 + i));
      // Queue is full now: this one is dropped.
      send_item(FUNC_INSERT, TIME_W'(1), 16'hA5A5);
      for (i = 0; i < 5; i++) send_item(FUNC_REMOVE, TIME_W'($urandom), TAG_W'($urandom));

      // Random phases: insert-heavy phases push into the full case,
      // remove-heavy ones into the empty case.
      n_sent     = 0;
      phase_left = 0;
      insert_pct = 50;
      no_gaps    = 1'b0;
      while (n_sent < N_RANDOM) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(10, 50);
            case ($urandom_range(0, 2))
               0:       insert_pct = 15;
               1:       insert_pct = 50;
               default: insert_pct = 85;
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
         end
         f = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
         send_item(f, pick_time(), TAG_W'($urandom));
         n_sent++;
         phase_left--;
         if (!no_gaps) idle_for(pick_gap());
      end

      // Drain: wait for every outstanding response, then let the block settle.
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.pending() != 0)
         $display("%0t: %0d responses never arrived", $time, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
